// File: design/tfd_pkg.sv
// ---------------------------------------------------------------------------
// tfd_pkg: shared definitions for the telemetry frame decoder
// Frame layout constants, stream widths and the base-64 symbol decode.
// ---------------------------------------------------------------------------
package tfd_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned POS_W    = 5;
    localparam int unsigned VALUE_W  = 10;
    localparam int unsigned FLAG_W   = 6;
    localparam int unsigned GROUPS   = 4;   // groups held in the value store
    localparam int unsigned GIDX_W   = 2;

    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned S_TUSER_W = 1;
    localparam int unsigned M_TDATA_W = 64;
    localparam int unsigned M_TUSER_W = 1;

    // frame positions
    localparam logic [POS_W-1:0] POS_FIRST  = 5'd0;
    localparam logic [POS_W-1:0] POS_GRP0   = 5'd2;
    localparam logic [POS_W-1:0] POS_GRP1   = 5'd5;
    localparam logic [POS_W-1:0] POS_GRP2   = 5'd8;
    localparam logic [POS_W-1:0] POS_GRP3   = 5'd11;
    localparam logic [POS_W-1:0] DIGIT_END  = 5'd15;
    localparam logic [POS_W-1:0] FRAME_LAST = 5'd16;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;  // 'A'
    localparam logic [CHAR_W-1:0] CH_UC_Z  = 8'h5A;  // 'Z'
    localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;  // 'a'
    localparam logic [CHAR_W-1:0] CH_LC_Z  = 8'h7A;  // 'z'
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;  // '/'

    localparam logic [CHAR_W-1:0] OFS_UC    = 8'd65;
    localparam logic [CHAR_W-1:0] OFS_LC    = 8'd71;
    localparam logic [CHAR_W-1:0] OFS_DIGIT = 8'd4;
    localparam logic [CHAR_W-1:0] OFS_PLUS  = 8'd19;
    localparam logic [CHAR_W-1:0] OFS_SLASH = 8'd16;

    typedef struct packed {
        logic              ok;
        logic [FLAG_W-1:0] value;
    } b64_t;

    // base-64 symbol decode; invalid symbols give ok = 0 and value 0
    function automatic b64_t b64_decode(input logic [CHAR_W-1:0] c);
        b64_t        res;
        logic [CHAR_W-1:0] sum;
        res.ok = 1'b1;
        sum    = '0;
        if (c inside {[CH_UC_A:CH_UC_Z]}) begin
            sum = c - OFS_UC;
        end else if (c inside {[CH_LC_A:CH_LC_Z]}) begin
            sum = c - OFS_LC;
        end else if (c inside {[CH_ZERO:CH_NINE]}) begin
            sum = c + OFS_DIGIT;
        end else if (c == CH_PLUS) begin
            sum = c + OFS_PLUS;
        end else if (c == CH_SLASH) begin
            sum = c + OFS_SLASH;
        end else begin
            res.ok = 1'b0;
        end
        res.value = sum[FLAG_W-1:0];
        return res;
    endfunction

endpackage

// File: design/telemetry_frame_decoder_top.sv
// ---------------------------------------------------------------------------
// telemetry_frame_decoder_top: 17-character telemetry frame decoder
// Five 3-digit decimal groups and two base-64 flag symbols in, one decoded
// frame item out after the last character.
// ---------------------------------------------------------------------------
//  channel | handshake          | tdata                      | tuser
//  --------+--------------------+----------------------------+---------------
//  s_      | s_tvalid/s_tready  | [7:0] rx_char              | [0] frame_start
//  m_      | m_tvalid/m_tready  | 5x10b values, 2x6b flags   | [0] frame_valid
//
//  One character item per cycle while not stalled; the frame state registers are
//  updated on the accept edge and the result lands in the output register.
//  The result item appears in the cycle after character 16 is accepted.
//  Input is stalled only while a result sits in the output register and
//  m_tready is low. aresetn is synchronous, active low, and returns the
//  decoder to position 0 with an empty output register.
// ---------------------------------------------------------------------------
module telemetry_frame_decoder_top
    import tfd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] rx_char
    input  logic [S_TUSER_W-1:0] s_tuser,   // [0] frame_start
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [9:0] first_pressure, [19:10] second_pressure, [29:20] vehicle_mass,
    // [39:30] primary_igniter_current, [49:40] secondary_igniter_current,
    // [55:50] valve_current_flags, [61:56] limit_switch_flags, [63:62] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser    // [0] frame_valid
);

    // frame state
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [FLAG_W-1:0]  flag_reg, flag_next;
    logic               err_reg, err_next;
    logic [VALUE_W-1:0] vals_reg [GROUPS];   // no reset: written every frame

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                 out_fv_reg, out_fv_next;

    logic               s_acc;
    logic [CHAR_W-1:0]  rx_char;
    logic               frame_start;
    logic               restart;
    logic [POS_W-1:0]   pos_eff;
    logic [VALUE_W-1:0] acc_eff;
    logic               err_eff;
    logic               is_digit;
    logic [VALUE_W-1:0] digit;
    logic [VALUE_W-1:0] acc_step;
    logic               grp_wr;
    logic [GIDX_W-1:0]  grp_idx;
    b64_t               sym;
    logic               emit;
    logic               fv;

    assign rx_char     = s_tdata[CHAR_W-1:0];
    assign frame_start = s_tuser[0];

    // output slot frees when empty or being drained this cycle
    assign s_tready = !out_valid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;

    // frame start (or an impossible position) restarts at position 0
    assign restart = frame_start || (pos_reg > FRAME_LAST);
    assign pos_eff = restart ? POS_FIRST : pos_reg;
    assign acc_eff = restart ? '0 : acc_reg;
    assign err_eff = restart ? 1'b0 : err_reg;

    assign is_digit = rx_char inside {[CH_ZERO:CH_NINE]};
    assign digit    = VALUE_W'(rx_char - CH_ZERO);
    // acc * 10 + digit, kept to 10 bits
    assign acc_step = {acc_eff[VALUE_W-4:0], 3'b000} + {acc_eff[VALUE_W-2:0], 1'b0} + digit;

    assign sym = b64_decode(rx_char);

    // group completion points
    always_comb begin
        grp_wr  = 1'b0;
        grp_idx = '0;
        case (pos_eff)
            POS_GRP0: begin grp_wr = 1'b1; grp_idx = 2'd0; end
            POS_GRP1: begin grp_wr = 1'b1; grp_idx = 2'd1; end
            POS_GRP2: begin grp_wr = 1'b1; grp_idx = 2'd2; end
            POS_GRP3: begin grp_wr = 1'b1; grp_idx = 2'd3; end
            default:  begin grp_wr = 1'b0; grp_idx = '0;   end
        endcase
    end

    assign emit = (pos_eff == FRAME_LAST);
    assign fv   = sym.ok && !err_eff;

    always_comb begin
        pos_next  = pos_reg;
        acc_next  = acc_reg;
        flag_next = flag_reg;
        err_next  = err_reg;
        if (s_acc) begin
            if (pos_eff < DIGIT_END) begin
                acc_next = is_digit ? acc_step : acc_eff;
                err_next = err_eff || !is_digit;
                if (grp_wr) begin
                    acc_next = '0;
                end
                pos_next = pos_eff + 1'b1;
            end else if (pos_eff == DIGIT_END) begin
                acc_next  = acc_eff;
                flag_next = sym.value;
                err_next  = err_eff || !sym.ok;
                pos_next  = pos_eff + 1'b1;
            end else begin
                acc_next = '0;
                err_next = 1'b0;
                pos_next = POS_FIRST;
            end
        end
    end

    // result assembly; invalid frames show all-zero fields
    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_fv_next    = out_fv_reg;
        if (s_acc && emit) begin
            out_valid_next = 1'b1;
            out_fv_next    = fv;
            if (fv) begin
                out_data_next = {2'b00, sym.value, flag_reg, acc_eff,
                                 vals_reg[3], vals_reg[2], vals_reg[1], vals_reg[0]};
            end else begin
                out_data_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= POS_FIRST;
            acc_reg       <= '0;
            flag_reg      <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            acc_reg       <= acc_next;
            flag_reg      <= flag_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        out_fv_reg   <= out_fv_next;
        if (s_acc && (pos_eff < DIGIT_END) && grp_wr) begin
            vals_reg[grp_idx] <= is_digit ? acc_step : acc_eff;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_fv_reg;

`ifndef SYNTHESIS
    // the position never leaves the frame
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= FRAME_LAST)
        else $error("frame position out of range");

    // accepting the last character always loads a result
    a_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && emit) |=> (out_valid_reg && pos_reg == POS_FIRST))
        else $error("last character did not produce a result");

    // a result only appears after an accepted item
    a_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(s_acc && emit))
        else $error("result without last character");

    // a failed frame shows no partial values
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_fv_reg) |-> (out_data_reg == '0))
        else $error("invalid frame carries data");
`endif

endmodule

// File: tb/telemetry_frame_decoder_top_test.sv
// ---------------------------------------------------------------------------
// telemetry_frame_decoder_top_test: self-checking bench for the frame decoder
// Streams 17-character telemetry frames into the decoder. Most frames are
// well formed with random content; the rest are corrupted, cut short or
// plain noise. Both sides idle in random bursts. Every character item
// accepted is fed to a decoding model held in a small scoreboard, and each
// decoded frame item that comes out is checked field by field against the
// oldest frame due.
// ---------------------------------------------------------------------------
module telemetry_frame_decoder_top_test;
    import tfd_pkg::*;

    localparam int unsigned FRAME_LEN  = 17;
    localparam int unsigned CHAR_ITEMS = 1850;
    localparam int unsigned CALM_FROM  = 1500;  // no idling past this item

    // one decoded frame, as it should leave the block
    typedef struct packed {
        logic [VALUE_W-1:0] first_pressure;
        logic [VALUE_W-1:0] second_pressure;
        logic [VALUE_W-1:0] vehicle_mass;
        logic [VALUE_W-1:0] primary_igniter_current;
        logic [VALUE_W-1:0] secondary_igniter_current;
        logic [FLAG_W-1:0]  valve_current_flags;
        logic [FLAG_W-1:0]  limit_switch_flags;
        logic               frame_valid;
    } frame_fields_t;

    // Decoding model plus the queue of frames due out of the block.
    class frame_decode_board;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] acc;
        logic [VALUE_W-1:0] groups [GROUPS];
        logic [FLAG_W-1:0]  valve_hold;
        logic               bad;
        frame_fields_t      frames_due [$];
        int                 mismatches;

        function new();
            pos        = '0;
            acc        = '0;
            valve_hold = '0;
            bad        = 1'b0;
            mismatches = 0;
            foreach (groups[i]) groups[i] = '0;
        endfunction

        // base-64 symbol to its 6-bit value; ok drops on a foreign symbol
        function logic [FLAG_W-1:0] sym_value(input logic [CHAR_W-1:0] c,
                                              output logic ok);
            ok = 1'b1;
            if (c >= CH_UC_A && c <= CH_UC_Z) return FLAG_W'(c - CH_UC_A);
            if (c >= CH_LC_A && c <= CH_LC_Z) return FLAG_W'(c - CH_LC_A + 26);
            if (c >= CH_ZERO && c <= CH_NINE) return FLAG_W'(c - CH_ZERO + 52);
            if (c == CH_PLUS)  return FLAG_W'(62);
            if (c == CH_SLASH) return FLAG_W'(63);
            ok = 1'b0;
            return '0;
        endfunction

        // one accepted character item; the last position queues a frame
        function void take_char(input logic [CHAR_W-1:0] c, input logic st);
            frame_fields_t     f;
            logic              ok;
            logic [FLAG_W-1:0] lim;
            if (st || pos > FRAME_LAST) begin
                pos = '0;
                acc = '0;
                bad = 1'b0;
            end
            if (pos < DIGIT_END) begin
                if (c >= CH_ZERO && c <= CH_NINE) begin
                    acc = VALUE_W'(acc * 10 + (c - CH_ZERO));
                end else begin
                    bad = 1'b1;     // accumulator holds its value
                end
                // groups 0..3 park in the store, the fifth stays in acc
                if (pos % 3 == 2 && pos / 3 < GROUPS) begin
                    groups[pos / 3] = acc;
                    acc             = '0;
                end
                pos = pos + 1'b1;
            end else if (pos == DIGIT_END) begin
                valve_hold = sym_value(c, ok);
                if (!ok) bad = 1'b1;
                pos = pos + 1'b1;
            end else begin
                lim = sym_value(c, ok);
                f   = '0;           // invalid frame shows zeros only
                if (ok && !bad) begin
                    f.first_pressure            = groups[0];
                    f.second_pressure           = groups[1];
                    f.vehicle_mass              = groups[2];
                    f.primary_igniter_current   = groups[3];
                    f.secondary_igniter_current = acc;
                    f.valve_current_flags       = valve_hold;
                    f.limit_switch_flags        = lim;
                    f.frame_valid               = 1'b1;
                end
                frames_due.push_back(f);
                pos = '0;
                acc = '0;
                bad = 1'b0;
            end
        endfunction

        function void report(input string msg);
            mismatches++;
            if (mismatches <= 10) $display("mismatch: %s", msg);
        endfunction

        function void cmp(input string name, input int want, input int got);
            if (want != got)
                report($sformatf("%s expected %0d, got %0d", name, want, got));
        endfunction

        // one accepted decoded-frame item
        function void check_frame(input logic [M_TDATA_W-1:0] d, input logic u);
            frame_fields_t want;
            if (frames_due.size() == 0) begin
                report($sformatf("frame item with none due, tdata %h", d));
                return;
            end
            want = frames_due.pop_front();
            cmp("first_pressure", want.first_pressure, d[9:0]);
            cmp("second_pressure", want.second_pressure, d[19:10]);
            cmp("vehicle_mass", want.vehicle_mass, d[29:20]);
            cmp("primary_igniter_current", want.primary_igniter_current, d[39:30]);
            cmp("secondary_igniter_current", want.secondary_igniter_current,
                d[49:40]);
            cmp("valve_current_flags", want.valve_current_flags, d[55:50]);
            cmp("limit_switch_flags", want.limit_switch_flags, d[61:56]);
            cmp("frame_valid", want.frame_valid, u);
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;    // [7:0] rx_char
    logic [S_TUSER_W-1:0] s_tuser  = '0;    // [0] frame_start
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [9:0] first_pressure, [19:10] second_pressure, [29:20] vehicle_mass,
    // [39:30] primary_igniter_current, [49:40] secondary_igniter_current,
    // [55:50] valve_current_flags, [61:56] limit_switch_flags, [63:62] zero
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;          // [0] frame_valid

    frame_decode_board board = new();

    int unsigned sent       = 0;    // character items accepted so far
    int unsigned stall_left = 0;    // cycles of m_tready low still to run
    bit          gaps_on    = 1'b0;
    bit          stalls_on  = 1'b0;

    always #1 aclk = ~aclk;

    telemetry_frame_decoder_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Result side: check on the accept edge, then pick the next ready level.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_frame(m_tdata, m_tuser[0]);
        if (stall_left != 0) begin
            stall_left--;
        end else if (stalls_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 8);
        end
        m_tready <= (stall_left == 0);
    end

    // Hard stop, far beyond the slowest legal run.
    initial begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end

    // base-64 symbol for a 6-bit value
    function automatic logic [CHAR_W-1:0] b64_symbol(input int v);
        if (v < 26) return CHAR_W'(CH_UC_A + v);
        if (v < 52) return CHAR_W'(CH_LC_A + v - 26);
        if (v < 62) return CHAR_W'(CH_ZERO + v - 52);
        if (v == 62) return CH_PLUS;
        return CH_SLASH;
    endfunction

    // group value, leaning on the extremes
    function automatic int pick_reading();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return 0;
        if (r == 1) return 999;
        return $urandom_range(0, 999);
    endfunction

    // Sender: optional gap, then hold the item until it is taken.
    // s_tvalid stays high between back-to-back items.
    task automatic push_char(input logic [CHAR_W-1:0] c, input logic st);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= st;
        do @(posedge aclk); while (!s_tready);
        board.take_char(c, st);
        sent++;
    endtask

    task automatic push_text(input string s, input logic st);
        for (int i = 0; i < s.len(); i++) push_char(s[i], st && i == 0);
    endtask

    initial begin
        logic [CHAR_W-1:0] chars [FRAME_LEN];
        int                kind;
        int                n;
        int                v;
        int                k;
        bit                need_start;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        gaps_on   = 1'b1;
        stalls_on = 1'b1;

        // directed: all-nines frame with top flags, then a dropped partial
        // frame (non-digit included) cut off by the next frame start
        push_text("999999999999999//", 1'b1);
        push_text("0Z", 1'b1);
        need_start = 1'b1;

        while (sent < CHAR_ITEMS) begin
            // idle in stretches, with calm stretches between, none at the end
            gaps_on   = (sent < CALM_FROM) && ((sent / 160) % 3 != 2);
            stalls_on = (sent < CALM_FROM) && ((sent / 200) % 4 != 3);

            kind = $urandom_range(0, 99);

            // well-formed body first; other kinds spoil it
            for (int g = 0; g < 5; g++) begin
                v = pick_reading();
                if (kind >= 60 && kind < 66) v = (kind < 63) ? 0 : 999;
                chars[3*g]     = CHAR_W'(CH_ZERO + v / 100);
                chars[3*g + 1] = CHAR_W'(CH_ZERO + (v / 10) % 10);
                chars[3*g + 2] = CHAR_W'(CH_ZERO + v % 10);
            end
            chars[15] = b64_symbol($urandom_range(0, 63));
            chars[16] = b64_symbol($urandom_range(0, 63));
            if (kind >= 60 && kind < 63) begin
                chars[15] = CH_UC_A;
                chars[16] = CH_UC_A;
            end else if (kind >= 63 && kind < 66) begin
                chars[15] = CH_SLASH;
                chars[16] = CH_PLUS;
            end
            n = FRAME_LEN;

            if (kind >= 66 && kind < 80) begin
                // corrupted: one or two characters replaced by any byte
                repeat ($urandom_range(1, 2)) begin
                    k        = $urandom_range(0, FRAME_LEN - 1);
                    chars[k] = CHAR_W'($urandom_range(0, 255));
                end
            end else if (kind >= 80 && kind < 92) begin
                n = $urandom_range(1, FRAME_LEN - 1);   // cut short
            end else if (kind >= 92) begin
                n = $urandom_range(1, 6);               // raw noise
                for (int i = 0; i < n; i++) chars[i] = CHAR_W'($urandom_range(0, 255));
            end

            for (int i = 0; i < n; i++) begin
                if (i == 0) begin
                    push_char(chars[i], need_start ? 1'b1 : 1'($urandom_range(0, 1)));
                end else if (kind >= 92) begin
                    push_char(chars[i], $urandom_range(0, 3) == 0);
                end else begin
                    push_char(chars[i], 1'b0);
                end
            end
            // after a short or noisy run the next frame must realign
            need_start = (kind >= 80);
        end

        s_tvalid  <= 1'b0;
        gaps_on   = 1'b0;
        stalls_on = 1'b0;

        while (board.frames_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);   // catch any stray frame item

        if (board.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
